// ===== hw/rtl/oht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Otsu threshold package
// Widths, types and codes shared by the Otsu histogram threshold modules.
// ----------------------------------------------------------------------------
package oht_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int GRAY_LEVELS = 256;
    localparam int AW          = $clog2(GRAY_LEVELS);
    localparam int SUM_BITS    = COUNT_BITS + AW;
    localparam int PROD_BITS   = COUNT_BITS + SUM_BITS;
    localparam int NUM_BITS    = 2 * PROD_BITS;
    localparam int DEN_BITS    = 2 * COUNT_BITS;
    localparam int MUL_A_BITS  = NUM_BITS;
    localparam int MUL_B_BITS  = PROD_BITS;
    localparam int MUL_P_BITS  = NUM_BITS + DEN_BITS;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [AW-1:0]         LAST_BIN  = AW'(GRAY_LEVELS - 1);

    typedef struct packed {
        logic       action;
        logic [7:0] pixel_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] threshold;
        logic       split_found;
        logic       count_overflow;
    } t_out_word;

    typedef struct packed {
        logic       valid;
        logic       finish;
        logic [7:0] gray;
    } t_head;

    typedef struct packed {
        logic pop;
        logic hold;
    } t_front_ctl;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_RUN,
        S_READ,
        S_ACC,
        S_MSTART,
        S_MWAIT,
        S_CMP,
        S_NEXT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_P,
        OP_Q,
        OP_NUM,
        OP_DEN,
        OP_LHS,
        OP_RHS
    } t_op;

endpackage

// ===== hw/rtl/oht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/oht_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Otsu front queue
// Accepts words and holds them in a short queue, flagging finish words.
// ----------------------------------------------------------------------------
module oht_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  oht_pkg::t_in_word   i_item,
    input  oht_pkg::t_front_ctl i_ctl,
    output oht_pkg::t_head      o_head
);

    oht_pkg::t_in_word             r_mem [oht_pkg::FIFO_DEPTH];
    logic [oht_pkg::FIFO_PW-1:0]   r_wr;
    logic [oht_pkg::FIFO_PW-1:0]   r_rd;
    logic [oht_pkg::FIFO_CW-1:0]   r_cnt;
    logic                          accept;
    logic                          take;

    assign full   = (r_cnt == oht_pkg::FIFO_CW'(oht_pkg::FIFO_DEPTH)) || i_ctl.hold;
    assign accept = push && !full;
    assign take   = i_ctl.pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_mem[r_wr] <= i_item;
                r_wr        <= r_wr + 1'b1;
            end
            if (take) begin
                r_rd <= r_rd + 1'b1;
            end
            if (accept && !take) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (take && !accept) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head.valid  = (r_cnt != '0);
    assign o_head.finish = r_mem[r_rd].action;
    assign o_head.gray   = r_mem[r_rd].pixel_value;

endmodule

// ===== hw/rtl/oht_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Otsu serial multiplier
// Shift-add multiplier taking one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module oht_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [oht_pkg::MUL_A_BITS-1:0]   i_a,
    input  logic [oht_pkg::MUL_B_BITS-1:0]   i_b,
    output logic                             o_done,
    output logic [oht_pkg::MUL_P_BITS-1:0]   o_prod
);

    logic [oht_pkg::MUL_P_BITS-1:0] r_acc;
    logic [oht_pkg::MUL_P_BITS-1:0] r_a;
    logic [oht_pkg::MUL_B_BITS-1:0] r_b;
    logic                           r_run;
    logic                           r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc <= '0;
                r_a   <= oht_pkg::MUL_P_BITS'(i_a);
                r_b   <= i_b;
                r_run <= 1'b1;
            end else if (r_run) begin
                if (r_b == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hw/rtl/oht_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Otsu back end
// Histogram update pipeline and the threshold scan sequencer.
// ----------------------------------------------------------------------------
module oht_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  oht_pkg::t_head      i_head,
    output oht_pkg::t_front_ctl o_ctl,
    input  logic                i_out_free,
    output oht_pkg::t_result    o_result
);

    localparam int CB = oht_pkg::COUNT_BITS;
    localparam int AW = oht_pkg::AW;
    localparam int SB = oht_pkg::SUM_BITS;
    localparam int PB = oht_pkg::PROD_BITS;
    localparam int NB = oht_pkg::NUM_BITS;
    localparam int DB = oht_pkg::DEN_BITS;
    localparam int MA = oht_pkg::MUL_A_BITS;
    localparam int MB = oht_pkg::MUL_B_BITS;
    localparam int MP = oht_pkg::MUL_P_BITS;

    oht_pkg::t_state r_state;
    oht_pkg::t_state n_state;
    oht_pkg::t_op    r_op;

    logic [AW-1:0] r_t;
    logic          r_b_valid;
    logic [AW-1:0] r_b_addr;
    logic          r_fw_valid;
    logic [AW-1:0] r_fw_addr;
    logic [CB-1:0] r_fw_data;
    logic [CB-1:0] r_total;
    logic [SB-1:0] r_gsum;
    logic          r_ovf;
    logic [CB-1:0] r_n0;
    logic [SB-1:0] r_s0;
    logic [CB-1:0] r_n1;
    logic [SB-1:0] r_s1;
    logic [PB-1:0] r_p;
    logic [PB-1:0] r_q;
    logic [NB-1:0] r_num;
    logic [DB-1:0] r_den;
    logic [MP-1:0] r_lhs;
    logic [MP-1:0] r_rhs;
    logic          r_found;
    logic [AW-1:0] r_best_t;
    logic [NB-1:0] r_best_num;
    logic [DB-1:0] r_best_den;

    logic          pix_go;
    logic          fin_go;
    logic          sat;
    logic [AW-1:0] gray_c;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [CB-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [CB-1:0] ram_rdata;
    logic [CB-1:0] b_wdata;
    logic [CB-1:0] n0_new;
    logic [SB-1:0] s0_new;
    logic [SB-1:0] tb;
    logic [CB-1:0] n1_new;
    logic [SB-1:0] s1_new;
    logic          skip;
    logic [PB-1:0] diff;
    logic          mul_start;
    logic          mul_done;
    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic [MP-1:0] mul_prod;
    logic          take;

    assign sat    = (r_total == oht_pkg::COUNT_MAX);
    assign gray_c = ({1'b0, i_head.gray} >= 9'(oht_pkg::GRAY_LEVELS))
                    ? oht_pkg::LAST_BIN : AW'(i_head.gray);
    assign b_wdata = ((r_fw_valid && (r_fw_addr == r_b_addr)) ? r_fw_data : ram_rdata)
                     + 1'b1;

    assign tb     = SB'(r_t) * SB'(ram_rdata);
    assign n0_new = r_n0 + ram_rdata;
    assign s0_new = r_s0 + tb;
    assign n1_new = r_total - n0_new;
    assign s1_new = r_gsum - s0_new;
    assign skip   = (n0_new == '0) || (n1_new == '0);
    assign diff   = (r_p >= r_q) ? (r_p - r_q) : (r_q - r_p);
    assign take   = !r_found || (r_lhs > r_rhs);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            oht_pkg::S_CLEAR: begin
                if (r_t == oht_pkg::LAST_BIN) begin
                    n_state = oht_pkg::S_RUN;
                end
            end
            oht_pkg::S_RUN: begin
                if (i_head.valid && i_head.finish && !r_b_valid) begin
                    n_state = oht_pkg::S_READ;
                end
            end
            oht_pkg::S_READ:   n_state = oht_pkg::S_ACC;
            oht_pkg::S_ACC: begin
                n_state = skip ? oht_pkg::S_NEXT : oht_pkg::S_MSTART;
            end
            oht_pkg::S_MSTART: n_state = oht_pkg::S_MWAIT;
            oht_pkg::S_MWAIT: begin
                if (mul_done) begin
                    n_state = (r_op == oht_pkg::OP_RHS) ? oht_pkg::S_CMP
                                                        : oht_pkg::S_MSTART;
                end
            end
            oht_pkg::S_CMP:    n_state = oht_pkg::S_NEXT;
            oht_pkg::S_NEXT: begin
                n_state = (r_t == oht_pkg::LAST_BIN) ? oht_pkg::S_OUT : oht_pkg::S_READ;
            end
            oht_pkg::S_OUT: begin
                if (i_out_free) begin
                    n_state = oht_pkg::S_RUN;
                end
            end
            default:           n_state = oht_pkg::S_CLEAR;
        endcase
    end

    // Control outputs.
    always_comb begin
        pix_go    = 1'b0;
        fin_go    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_t;
        ram_wdata = '0;
        ram_raddr = r_t;
        mul_start = 1'b0;
        o_ctl.hold = 1'b0;
        o_result.valid = 1'b0;
        case (r_state)
            oht_pkg::S_CLEAR: begin
                ram_we     = 1'b1;
                o_ctl.hold = 1'b1;
            end
            oht_pkg::S_RUN: begin
                pix_go = i_head.valid && !i_head.finish;
                fin_go = i_head.valid && i_head.finish && !r_b_valid;
                if (pix_go) begin
                    ram_raddr = gray_c;
                end
            end
            oht_pkg::S_READ: begin
                ram_we = 1'b1;
            end
            oht_pkg::S_MSTART: begin
                mul_start = 1'b1;
            end
            oht_pkg::S_OUT: begin
                o_result.valid = i_out_free;
            end
            default: begin
                pix_go = 1'b0;
            end
        endcase
        if (r_b_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_b_addr;
            ram_wdata = b_wdata;
        end
        o_ctl.pop = pix_go || fin_go;
        o_result.word.threshold      = 8'(r_best_t);
        o_result.word.split_found    = r_found;
        o_result.word.count_overflow = r_ovf;
    end

    // Multiplier operands.
    always_comb begin
        mul_a = MA'(r_s0);
        mul_b = MB'(r_n1);
        case (r_op)
            oht_pkg::OP_P: begin
                mul_a = MA'(r_s0);
                mul_b = MB'(r_n1);
            end
            oht_pkg::OP_Q: begin
                mul_a = MA'(r_s1);
                mul_b = MB'(r_n0);
            end
            oht_pkg::OP_NUM: begin
                mul_a = MA'(diff);
                mul_b = MB'(diff);
            end
            oht_pkg::OP_DEN: begin
                mul_a = MA'(r_n0);
                mul_b = MB'(r_n1);
            end
            oht_pkg::OP_LHS: begin
                mul_a = MA'(r_num);
                mul_b = MB'(r_best_den);
            end
            oht_pkg::OP_RHS: begin
                mul_a = MA'(r_best_num);
                mul_b = MB'(r_den);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= oht_pkg::S_CLEAR;
            r_op       <= oht_pkg::OP_P;
            r_t        <= '0;
            r_b_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
            r_total    <= '0;
            r_gsum     <= '0;
            r_ovf      <= 1'b0;
            r_found    <= 1'b0;
            r_best_t   <= '0;
        end else begin
            r_state    <= n_state;
            r_b_valid  <= pix_go && !sat;
            r_b_addr   <= gray_c;
            r_fw_valid <= r_b_valid;
            r_fw_addr  <= r_b_addr;
            r_fw_data  <= b_wdata;
            case (r_state)
                oht_pkg::S_CLEAR: begin
                    r_t <= (r_t == oht_pkg::LAST_BIN) ? '0 : r_t + 1'b1;
                end
                oht_pkg::S_RUN: begin
                    if (pix_go) begin
                        if (sat) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_total <= r_total + 1'b1;
                            r_gsum  <= r_gsum + SB'(gray_c);
                        end
                    end
                    if (fin_go) begin
                        r_t        <= '0;
                        r_n0       <= '0;
                        r_s0       <= '0;
                        r_found    <= 1'b0;
                        r_best_t   <= '0;
                        r_best_num <= '0;
                        r_best_den <= DB'(1);
                    end
                end
                oht_pkg::S_ACC: begin
                    r_n0 <= n0_new;
                    r_s0 <= s0_new;
                    r_n1 <= n1_new;
                    r_s1 <= s1_new;
                    r_op <= oht_pkg::OP_P;
                end
                oht_pkg::S_MWAIT: begin
                    if (mul_done) begin
                        case (r_op)
                            oht_pkg::OP_P: begin
                                r_p  <= mul_prod[PB-1:0];
                                r_op <= oht_pkg::OP_Q;
                            end
                            oht_pkg::OP_Q: begin
                                r_q  <= mul_prod[PB-1:0];
                                r_op <= oht_pkg::OP_NUM;
                            end
                            oht_pkg::OP_NUM: begin
                                r_num <= mul_prod[NB-1:0];
                                r_op  <= oht_pkg::OP_DEN;
                            end
                            oht_pkg::OP_DEN: begin
                                r_den <= mul_prod[DB-1:0];
                                r_op  <= oht_pkg::OP_LHS;
                            end
                            oht_pkg::OP_LHS: begin
                                r_lhs <= mul_prod;
                                r_op  <= oht_pkg::OP_RHS;
                            end
                            oht_pkg::OP_RHS: begin
                                r_rhs <= mul_prod;
                                r_op  <= oht_pkg::OP_P;
                            end
                            default: begin
                                r_op <= oht_pkg::OP_P;
                            end
                        endcase
                    end
                end
                oht_pkg::S_CMP: begin
                    if (take) begin
                        r_found    <= 1'b1;
                        r_best_t   <= r_t;
                        r_best_num <= r_num;
                        r_best_den <= r_den;
                    end
                end
                oht_pkg::S_NEXT: begin
                    if (r_t != oht_pkg::LAST_BIN) begin
                        r_t <= r_t + 1'b1;
                    end
                end
                oht_pkg::S_OUT: begin
                    if (i_out_free) begin
                        r_total <= '0;
                        r_gsum  <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: begin
                    r_op <= r_op;
                end
            endcase
        end
    end

    oht_ram #(
        .WIDTH (CB),
        .DEPTH (oht_pkg::GRAY_LEVELS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    oht_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

endmodule

// ===== hw/rtl/otsu_histogram_threshold.sv =====
`timescale 1ns / 1ps
// Pixel words are taken at one per cycle while the back end is in S_RUN; each bin is
// read at the pop and its incremented count written back from the r_b stage. A finish
// word yields its result after a scan of every gray level: a level with an empty class
// skips the multiplies, else six products are formed on the serial multiplier.
// The serial shift-add multiplier, one operand bit per cycle, sets the scan time.
// Reset is synchronous; afterwards the histogram is zeroed bin by bin, all 256 bins, with full high.
// ----------------------------------------------------------------------------
// Otsu histogram threshold
// Builds a gray-level histogram and returns the Otsu threshold on finish.
// ----------------------------------------------------------------------------
module otsu_histogram_threshold (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  oht_pkg::t_in_word  i_item,
    output logic               empty,
    input  logic               pop,
    output oht_pkg::t_out_word o_result
);

    // The front queue decouples the pixel stream from the back end, which
    // stalls while a finish word is being scanned.
    oht_pkg::t_head      head;
    oht_pkg::t_front_ctl ctl;
    oht_pkg::t_result    result;

    // One-word result register: the scan of the next frame only waits on it
    // when its own result is ready and the previous word was never taken.
    logic               r_out_valid;
    oht_pkg::t_out_word r_out;
    logic               out_free;

    assign out_free = !r_out_valid;

    oht_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .i_ctl   (ctl),
        .o_head  (head)
    );

    oht_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_ctl      (ctl),
        .i_out_free (out_free),
        .o_result   (result)
    );

    // A result only loads when the register is free, so a load and a pop
    // never fall in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_out <= result.word;
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

endmodule

// ===== verif/otsu_histogram_threshold_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Otsu histogram threshold testbench
// Streams pixel and finish words into the block with random gaps on both
// sides and compares every threshold result with a built-in predictor.
// ----------------------------------------------------------------------------
module otsu_histogram_threshold_tb;

    // Scoreboard: keeps its own histogram and the queue of predicted results.
    class otsu_scoreboard;
        bit [23:0]  hist[256];
        bit [23:0]  npix;
        bit [63:0]  gsum;
        bit         dropped;
        oht_pkg::t_out_word pending_results[$];
        int         n_errors;
        int         n_checked;

        function void clear_frame();
            foreach (hist[i]) hist[i] = '0;
            npix = '0;
            gsum = '0;
            dropped = 1'b0;
        endfunction

        // Called for every word the block accepts.
        function void note_word(oht_pkg::t_in_word w);
            bit [63:0]  n0, s0, n1, s1, den, bden;
            bit [127:0] diff, num, bnum;
            bit [255:0] lhs, rhs;
            oht_pkg::t_out_word r;
            bit         found;
            if (!w.action) begin
                if (npix == 24'hFFFFFF) begin
                    dropped = 1'b1;
                end else begin
                    hist[w.pixel_value]++;
                    npix++;
                    gsum += w.pixel_value;
                end
                return;
            end
            n0 = 0; s0 = 0; found = 0; bnum = 0; bden = 1;
            r = '0;
            for (int t = 0; t < 255; t++) begin
                n0 += hist[t];
                s0 += 64'(t) * hist[t];
                n1 = npix - n0;
                s1 = gsum - s0;
                if (n0 == 0 || n1 == 0) continue;
                if (n1 * s0 >= n0 * s1) diff = n1 * s0 - n0 * s1;
                else diff = n0 * s1 - n1 * s0;
                num = diff * diff;
                den = n0 * n1;
                lhs = 256'(num) * bden;
                rhs = 256'(bnum) * den;
                if (!found || lhs > rhs) begin
                    found = 1;
                    r.threshold = 8'(t);
                    bnum = num;
                    bden = den;
                end
            end
            r.split_found = found;
            r.count_overflow = dropped;
            pending_results.push_back(r);
            clear_frame();
        endfunction

        function void check_result(oht_pkg::t_out_word got);
            oht_pkg::t_out_word e;
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", got);
                n_errors++;
                return;
            end
            e = pending_results.pop_front();
            n_checked++;
            if (got.threshold !== e.threshold) begin
                $error("threshold expected %0d actual %0d", e.threshold, got.threshold);
                n_errors++;
            end
            if (got.split_found !== e.split_found) begin
                $error("split_found expected %0b actual %0b", e.split_found, got.split_found);
                n_errors++;
            end
            if (got.count_overflow !== e.count_overflow) begin
                $error("count_overflow expected %0b actual %0b",
                       e.count_overflow, got.count_overflow);
                n_errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    oht_pkg::t_in_word  i_item;
    logic       empty;
    logic       pop;
    oht_pkg::t_out_word o_result;

    otsu_scoreboard sb;
    longint unsigned cycle_count;
    int n_pixels;
    int n_frames;
    bit send_done;
    // The scan of each frame dominates the run time, and a run has well under
    // a hundred frames, so this limit leaves a wide margin.
    localparam longint unsigned CYCLE_LIMIT = 64'd80_000_000;

    otsu_histogram_threshold dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("otsu_histogram_threshold verification failed");
            $finish;
        end
    end

    // Result side: pop with random stalls, check on each accepted word.
    initial begin : result_side
        int stall;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                sb.check_result(o_result);
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                if (stall != 0) pop <= 1'b0;
            end else if (!pop) begin
                stall = (stall > 0) ? stall - 1 : 0;
                if (stall == 0) pop <= 1'b1;
            end
        end
    end

    // Sends one word, keeping push high when the next word follows at once.
    task automatic send_word(input logic act, input logic [7:0] g, input bit burst);
        int gap;
        gap = burst ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14));
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item.action <= act;
        i_item.pixel_value <= g;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        sb.note_word('{action: act, pixel_value: g});
        if (act) n_frames++;
        else n_pixels++;
    endtask

    task automatic send_pixel(input logic [7:0] g);
        send_word(1'b0, g, 1'b0);
    endtask

    task automatic send_finish();
        send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial begin : stimulus
        int npx, lo, hi, mode;
        sb = new();
        sb.clear_frame();
        sb.n_errors = 0;
        sb.n_checked = 0;
        cycle_count = 0;
        n_pixels = 0;
        n_frames = 0;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_item <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty frame, single gray level, the two extreme levels,
        // a two-way tie where the lower threshold must win.
        send_finish();
        send_pixel(8'd0); send_pixel(8'd0); send_finish();
        send_pixel(8'd255); send_finish();
        send_pixel(8'd0); send_pixel(8'd255); send_finish();
        send_pixel(8'd0); send_pixel(8'd1); send_pixel(8'd2); send_finish();
        send_pixel(8'haa); send_pixel(8'h55); send_pixel(8'h0f);
        send_pixel(8'hf0); send_finish();

        // Random frames, mostly small, with clustered or spread gray levels.
        while (n_pixels + n_frames < 1200) begin
            npx = $urandom_range(0, 40);
            mode = $urandom_range(0, 3);
            lo = $urandom_range(0, 255);
            hi = $urandom_range(lo, 255);
            repeat (npx) begin
                case (mode)
                    0: send_pixel(8'($urandom_range(0, 255)));
                    1: send_pixel(8'($urandom_range(lo, hi)));
                    2: send_pixel(($urandom_range(0, 1) != 0) ? 8'(lo) : 8'(hi));
                    default: send_pixel(($urandom_range(0, 1) != 0) ?
                                        8'($urandom_range(0, 255)) : 8'(lo));
                endcase
            end
            send_finish();
        end
        push <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Covered %0d pixel words and %0d finish words; %0d results checked.",
                 n_pixels, n_frames, sb.n_checked);
        if (sb.n_errors == 0) begin
            $display("otsu_histogram_threshold verification clean");
        end else begin
            $display("otsu_histogram_threshold verification failed");
        end
        $finish;
    end
endmodule

// ===== otsu_histogram_threshold.f =====
hw/rtl/oht_pkg.sv
hw/rtl/oht_ram.sv
hw/rtl/oht_front.sv
hw/rtl/oht_mul.sv
hw/rtl/oht_back.sv
hw/rtl/otsu_histogram_threshold.sv
verif/otsu_histogram_threshold_tb.sv
